@@ sv/fqa_pkg.sv @@
// ----------------------------------------------------------------------------
// fqa_pkg
// Shared types, constants and the coefficient table of the arctangent block.
// ----------------------------------------------------------------------------
package fqa_pkg;

   localparam int IN_WIDTH      = 16;
   localparam int OUT_WIDTH     = 16;
   localparam int RATIO_WIDTH   = 16;
   localparam int ACC_WIDTH     = 28;
   localparam int PROD_WIDTH    = ACC_WIDTH + RATIO_WIDTH + 1;
   localparam int RATIO_FRAC    = 15;
   localparam int COEF_FRAC     = 24;
   localparam int ANGLE_FRAC    = 13;
   localparam int OUT_SHIFT     = COEF_FRAC - ANGLE_FRAC;
   localparam int POLY_TERMS    = 10;
   localparam int DIV_STAGES    = RATIO_WIDTH;
   localparam int HORNER_STAGES = POLY_TERMS - 1;

   localparam logic signed [ACC_WIDTH-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [ACC_WIDTH-1:0] PI_Q24      = 28'sd52707179;

   typedef enum logic [2:0] {
      OP_ZERO,
      OP_PI,
      OP_POS,
      OP_NEG,
      OP_PI_SUB,
      OP_SUB_PI
   } op_type;

   typedef struct packed {
      logic [IN_WIDTH-1:0] hi;
      logic [IN_WIDTH-1:0] lo;
      logic                swap;
      op_type              op;
   } item_type;

   typedef struct packed {
      logic swap;
      op_type op;
   } meta_type;

   function automatic logic signed [ACC_WIDTH-1:0] coef(input logic [3:0] k);
      logic signed [ACC_WIDTH-1:0] c;
      case (k)
         4'd1:    c = 28'sd16777219;
         4'd2:    c = -28'sd384;
         4'd3:    c = -28'sd5583603;
         4'd4:    c = -28'sd73901;
         4'd5:    c = 28'sd3627599;
         4'd6:    c = -28'sd348135;
         4'd7:    c = -28'sd2928066;
         4'd8:    c = 28'sd2249082;
         4'd9:    c = -28'sd543018;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

@@ sv/fqa_front.sv @@
// ----------------------------------------------------------------------------
// fqa_front
// Forms magnitudes of the signed inputs, orders them and picks the quadrant correction.
// ----------------------------------------------------------------------------
module fqa_front (
   input  logic [fqa_pkg::IN_WIDTH-1:0] y_value,
   input  logic [fqa_pkg::IN_WIDTH-1:0] x_value,
   output fqa_pkg::item_type            item
);

   logic [fqa_pkg::IN_WIDTH-1:0] ay;
   logic [fqa_pkg::IN_WIDTH-1:0] ax;
   logic y_neg, x_neg, y_zero, x_zero;

   always_comb begin
      y_neg  = y_value[fqa_pkg::IN_WIDTH-1];
      x_neg  = x_value[fqa_pkg::IN_WIDTH-1];
      y_zero = (y_value == '0);
      x_zero = (x_value == '0);
      ay = y_neg ? (~y_value + 1'b1) : y_value;
      ax = x_neg ? (~x_value + 1'b1) : x_value;
      item.swap = (ay > ax);
      item.hi   = item.swap ? ay : ax;
      item.lo   = item.swap ? ax : ay;
      if (x_zero && y_zero) begin
         item.op = fqa_pkg::OP_ZERO;
      end else if (!x_neg) begin
         item.op = y_neg ? fqa_pkg::OP_NEG : fqa_pkg::OP_POS;
      end else if (y_zero) begin
         item.op = fqa_pkg::OP_PI;
      end else begin
         item.op = y_neg ? fqa_pkg::OP_SUB_PI : fqa_pkg::OP_PI_SUB;
      end
   end

endmodule

@@ sv/fqa_queue.sv @@
// ----------------------------------------------------------------------------
// fqa_queue
// Two-entry queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module fqa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  fqa_pkg::item_type push_item,
   output logic              full,
   output logic              pop_valid,
   output fqa_pkg::item_type pop_item,
   input  logic              pop
);

   fqa_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      pop_valid = (count_ff != 2'd0);
      pop_item  = entry_ff[rd_ptr_ff];
      do_push   = push_valid && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/fqa_back.sv @@
// ----------------------------------------------------------------------------
// fqa_back
// Pipelined ratio divider, Horner polynomial, quadrant correction and output rounding.
// ----------------------------------------------------------------------------
module fqa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  fqa_pkg::item_type             item,
   output logic                          item_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fqa_pkg::OUT_WIDTH-1:0] rsp_angle,
   output logic                          advance
);

   localparam int DS = fqa_pkg::DIV_STAGES;
   localparam int HS = fqa_pkg::HORNER_STAGES;
   localparam int RW = fqa_pkg::RATIO_WIDTH;
   localparam int AW = fqa_pkg::ACC_WIDTH;
   localparam int PW = fqa_pkg::PROD_WIDTH;

   // divider stages: one quotient bit each
   logic [RW-1:0]      drem_ff [DS];
   logic [RW-1:0]      drem_in [DS];
   logic [RW-1:0]      dq_ff   [DS];
   logic [RW-1:0]      dq_in   [DS];
   logic [RW-1:0]      dhi_ff  [DS];
   fqa_pkg::meta_type  dmeta_ff [DS];
   logic [DS-1:0]      dvalid_ff;

   // polynomial stages: one multiply each
   logic signed [AW-1:0] hacc_ff [HS];
   logic signed [AW-1:0] hacc_in [HS];
   logic [RW-1:0]        hr_ff   [HS];
   fqa_pkg::meta_type    hmeta_ff [HS];
   logic [HS-1:0]        hvalid_ff;

   logic signed [AW-1:0] ang_ff, ang_in;
   logic                 ang_valid_ff;
   logic [fqa_pkg::OUT_WIDTH-1:0] angle_ff, angle_in;
   logic                 out_valid_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign item_pop  = advance && item_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_angle = angle_ff;

   for (genvar s = 0; s < DS; s++) begin : g_div
      logic [RW:0]   rem;
      logic [RW-1:0] hi;
      logic [RW-1:0] q_prev;
      logic          ge;
      always_comb begin
         if (s == 0) begin
            rem    = {1'b0, item.lo};
            hi     = item.hi;
            q_prev = '0;
         end else begin
            rem    = {drem_ff[(s == 0) ? 0 : s-1], 1'b0};
            hi     = dhi_ff[(s == 0) ? 0 : s-1];
            q_prev = dq_ff[(s == 0) ? 0 : s-1];
         end
         ge         = (rem >= {1'b0, hi});
         drem_in[s] = ge ? RW'(rem - {1'b0, hi}) : rem[RW-1:0];
         dq_in[s]   = q_prev | (RW'(ge) << (RW - 1 - s));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvalid_ff[s] <= 1'b0;
         end else if (advance) begin
            dvalid_ff[s] <= (s == 0) ? item_valid : dvalid_ff[(s == 0) ? 0 : s-1];
         end
         if (advance) begin
            drem_ff[s] <= drem_in[s];
            dq_ff[s]   <= dq_in[s];
            if (s == 0) begin
               dhi_ff[s]        <= item.hi;
               dmeta_ff[s].swap <= item.swap;
               dmeta_ff[s].op   <= item.op;
            end else begin
               dhi_ff[s]   <= dhi_ff[(s == 0) ? 0 : s-1];
               dmeta_ff[s] <= dmeta_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   for (genvar j = 0; j < HS; j++) begin : g_horner
      logic signed [AW-1:0] acc_prev;
      logic [RW-1:0]        r;
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] rnd;
      always_comb begin
         if (j == 0) begin
            acc_prev = fqa_pkg::coef(4'(fqa_pkg::POLY_TERMS - 1));
            r        = dq_ff[DS-1];
         end else begin
            acc_prev = hacc_ff[(j == 0) ? 0 : j-1];
            r        = hr_ff[(j == 0) ? 0 : j-1];
         end
         prod       = $signed({1'b0, r}) * acc_prev;
         rnd        = (prod + (PW'(1) <<< (fqa_pkg::RATIO_FRAC - 1)))
                      >>> fqa_pkg::RATIO_FRAC;
         hacc_in[j] = $signed(rnd[AW-1:0]) + fqa_pkg::coef(4'(HS - 1 - j));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            hvalid_ff[j] <= 1'b0;
         end else if (advance) begin
            hvalid_ff[j] <= (j == 0) ? dvalid_ff[DS-1] : hvalid_ff[(j == 0) ? 0 : j-1];
         end
         if (advance) begin
            hacc_ff[j]  <= hacc_in[j];
            hr_ff[j]    <= r;
            hmeta_ff[j] <= (j == 0) ? dmeta_ff[DS-1] : hmeta_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // base angle and quadrant fix
   always_comb begin
      logic signed [AW-1:0] base;
      base = hmeta_ff[HS-1].swap ? (fqa_pkg::HALF_PI_Q24 - hacc_ff[HS-1]) : hacc_ff[HS-1];
      case (hmeta_ff[HS-1].op)
         fqa_pkg::OP_ZERO:   ang_in = '0;
         fqa_pkg::OP_PI:     ang_in = fqa_pkg::PI_Q24;
         fqa_pkg::OP_POS:    ang_in = base;
         fqa_pkg::OP_NEG:    ang_in = -base;
         fqa_pkg::OP_PI_SUB: ang_in = fqa_pkg::PI_Q24 - base;
         fqa_pkg::OP_SUB_PI: ang_in = base - fqa_pkg::PI_Q24;
         default:            ang_in = '0;
      endcase
   end

   // round half up to the output scale
   always_comb begin
      logic signed [AW-1:0] t;
      t        = (ang_ff + (AW'(1) <<< (fqa_pkg::OUT_SHIFT - 1))) >>> fqa_pkg::OUT_SHIFT;
      angle_in = t[fqa_pkg::OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         ang_valid_ff <= hvalid_ff[HS-1];
         out_valid_ff <= ang_valid_ff;
      end
      if (advance) begin
         ang_ff   <= ang_in;
         angle_ff <= angle_in;
      end
   end

endmodule

@@ sv/four_quadrant_arctangent.sv @@
// ----------------------------------------------------------------------------
// four_quadrant_arctangent
// Four-quadrant arctangent of a signed vector by fixed-point polynomial.
// ----------------------------------------------------------------------------
// Takes one vector (y, x) per transfer and returns its angle in radians times
// 8192, from -pi to pi; the origin gives 0 and the negative x axis gives +pi.
// One transfer is taken every clock as long as the result side keeps up.
// The vector passes through the input queue, the ratio divider (one quotient
// bit per stage), the Horner polynomial (one multiply per stage), the quadrant
// fix register and the output rounding register. A stall on rsp_ while a
// result is valid freezes the whole arithmetic pipeline; the two-entry queue
// absorbs input until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module four_quadrant_arctangent (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fqa_pkg::IN_WIDTH-1:0]  req_y_value,
   input  logic [fqa_pkg::IN_WIDTH-1:0]  req_x_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fqa_pkg::OUT_WIDTH-1:0] rsp_angle
);

   fqa_pkg::item_type front_item;
   fqa_pkg::item_type queue_item;
   logic queue_full;
   logic queue_valid;
   logic queue_pop;
   logic back_advance;

   // classify the incoming vector
   fqa_front u_front (
      .y_value (req_y_value),
      .x_value (req_x_value),
      .item    (front_item)
   );

   // hold classified items until the pipeline advances
   fqa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_item  (front_item),
      .full       (queue_full),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop        (queue_pop)
   );

   assign req_stall = queue_full;

   // divide, evaluate the polynomial, correct the quadrant
   fqa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_angle  (rsp_angle),
      .advance    (back_advance)
   );

   // the pipeline only pops when it advances
   a_pop_on_advance: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> back_advance && queue_valid)
      else $error("queue popped without pipeline advance");

   // a stalled result freezes the pipeline
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !back_advance)
      else $error("pipeline advanced under output stall");

   // delivered angles stay within -pi..pi
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_angle) <= 16'sd25736) && ($signed(rsp_angle) >= -16'sd25736))
      else $error("angle out of range");

endmodule

@@ tb/sv/four_quadrant_arctangent_tb.sv @@
// ----------------------------------------------------------------------------
// four_quadrant_arctangent_tb
// Self-checking bench for the four-quadrant arctangent block.
// ----------------------------------------------------------------------------
// Drive vectors (y, x) through the request channel in random bursts while the
// response side stalls on its own pattern. Predict every angle with a local
// fixed-point model (ratio, Horner polynomial, quadrant fix, rounding) and
// compare each response transfer against the oldest predicted angle.
// ----------------------------------------------------------------------------
module four_quadrant_arctangent_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 28;
   localparam int CYCLE_LIMIT = 400000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [fqa_pkg::IN_WIDTH-1:0]  req_y_value;
   logic [fqa_pkg::IN_WIDTH-1:0]  req_x_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [fqa_pkg::OUT_WIDTH-1:0] rsp_angle;

   // Angles waiting for their response transfer, oldest first.
   logic [fqa_pkg::OUT_WIDTH-1:0] pending_angles[$];
   int                   mismatch_count = 0;
   int                   angles_checked = 0;
   longint               cycle_count = 0;
   // Stall pattern of the response side, changed by the test tasks.
   int                   stall_percent;

   four_quadrant_arctangent DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_y_value (req_y_value),
      .req_x_value (req_x_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_angle   (rsp_angle)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Round half up by s bits, floor semantics on negatives.
   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint poly_coef(input int k);
      case (k)
         1:       return 16777219;
         2:       return -384;
         3:       return -5583603;
         4:       return -73901;
         5:       return 3627599;
         6:       return -348135;
         7:       return -2928066;
         8:       return 2249082;
         9:       return -543018;
         default: return 0;
      endcase
   endfunction

   // Compute the expected angle of vector (y, x), radians times 2^13.
   function automatic logic [fqa_pkg::OUT_WIDTH-1:0] predict_angle(
         input logic signed [15:0] y, input logic signed [15:0] x);
      longint ay, ax, lo, hi, ratio, acc, base, ang;
      ay = (y < 0) ? -longint'(y) : longint'(y);
      ax = (x < 0) ? -longint'(x) : longint'(x);
      if (ax == 0 && ay == 0) begin
         ang = 0;
      end else begin
         if (ay > ax) begin
            lo = ax;
            hi = ay;
         end else begin
            lo = ay;
            hi = ax;
         end
         ratio = (lo <<< fqa_pkg::RATIO_FRAC) / hi;
         acc = poly_coef(fqa_pkg::POLY_TERMS - 1);
         for (int k = fqa_pkg::POLY_TERMS - 2; k >= 0; k--)
            acc = round_half_up(ratio * acc, fqa_pkg::RATIO_FRAC) + poly_coef(k);
         base = (ay > ax) ? longint'(fqa_pkg::HALF_PI_Q24) - acc : acc;
         if (x < 0) begin
            if (y > 0)
               ang = longint'(fqa_pkg::PI_Q24) - base;
            else if (y < 0)
               ang = base - longint'(fqa_pkg::PI_Q24);
            else
               ang = longint'(fqa_pkg::PI_Q24);
         end else begin
            ang = (y < 0) ? -base : base;
         end
      end
      return fqa_pkg::OUT_WIDTH'(round_half_up(ang, fqa_pkg::OUT_SHIFT));
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Send one vector; hold the payload until the transfer and leave valid high
   // for the next send or idle_request to change (no lower-then-raise in a step).
   task automatic send_vector(input logic [15:0] y, input logic [15:0] x);
      req_valid   <= 1'b1;
      req_y_value <= y;
      req_x_value <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_angles.push_back(predict_angle(y, x));
   endtask

   task automatic idle_request(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every predicted angle has come back.
   task automatic drain_pending();
      idle_request(1);
      while (pending_angles.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_component();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'($signed($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // Axes, origin, full scale, diagonals, every quadrant.
   task automatic test_special_vectors();
      logic [15:0] y_list[$];
      logic [15:0] x_list[$];
      y_list = '{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h8000,
                 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h1234, 16'hedcc,
                 16'h8000, 16'h0001, 16'h7fff, 16'h5555, 16'haaaa, 16'h0000,
                 16'h8000, 16'h0003};
      x_list = '{16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000,
                 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'h1234, 16'h1234,
                 16'h7fff, 16'h8000, 16'h8000, 16'haaaa, 16'h5555, 16'hffff,
                 16'hffff, 16'h0007};
      stall_percent = 0;
      foreach (y_list[i]) send_vector(y_list[i], x_list[i]);
      drain_pending();
   endtask

   // Random vectors in bursts with random gaps; change stall pattern per phase.
   task automatic test_random_vectors(input int count, input int stall_level);
      int sent;
      int burst;
      sent = 0;
      stall_percent = stall_level;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_vector(random_component(), random_component());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_request($urandom_range(1, 12));
      end
      drain_pending();
   endtask

   // Response stall pattern: each cycle stalls at random with stall_percent odds.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < stall_percent);
   end

   // Check each response transfer against the oldest predicted angle.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("unexpected angle %0d", $signed(rsp_angle)));
         end else begin
            if (rsp_angle !== pending_angles[0])
               report_mismatch($sformatf("angle %0d, predicted %0d",
                                         $signed(rsp_angle), $signed(pending_angles[0])));
            void'(pending_angles.pop_front());
            angles_checked++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_y_value    = '0;
      req_x_value    = '0;
      stall_percent  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_vectors();
      test_random_vectors(500, 0);
      test_random_vectors(500, 30);
      test_random_vectors(550, 80);

      repeat (LATENCY + 10) @(posedge clock);
      if (pending_angles.size() != 0)
         report_mismatch($sformatf("%0d angles never came", pending_angles.size()));
      $display("covered axes, origin, full scale and %0d checked angles", angles_checked);
      $display("under no, moderate and heavy response stalls with bursty requests");
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
